[rtl/wsgd_pkg.sv]
// Shared types, widths and constants of the wheel speed drive.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package wsgd_pkg;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_W  = 48;
	localparam int OUT_W = 48;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_SCALE = 3'd0,
		REG_GAIN_SLOPE  = 3'd1,
		REG_GAIN_OFFSET = 3'd2,
		REG_STEP_LIMIT  = 3'd3,
		REG_DEADBAND    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] speed_scale;
		logic [23:0] gain_slope;
		logic [15:0] gain_offset;
		logic [9:0]  step_limit;
		logic [15:0] deadband;
	} cfg_t;

	localparam logic [15:0] SPEED_SCALE_RST = 16'd23743;
	localparam logic [23:0] GAIN_SLOPE_RST  = 24'd343597;
	localparam logic [15:0] GAIN_OFFSET_RST = 16'd11796;
	localparam logic [9:0]  STEP_LIMIT_RST  = 10'd100;
	localparam logic [15:0] DEADBAND_RST    = 16'd256;

	// Drive accumulator codes.
	localparam logic [10:0] DRIVE_RESET   = 11'd1024;
	localparam logic [10:0] DRIVE_MAX     = 11'd2047;
	localparam logic [10:0] DRIVE_STOP_LO = 11'd1023;
	localparam logic [10:0] DRIVE_STOP_HI = 11'd1024;

	// Shared serial multiplier: signed A times signed B, one B bit per cycle.
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 25;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	typedef struct packed {
		logic                      start;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

[rtl/wsgd_cfg.sv]
// Configuration register file of the wheel speed drive.
// Depends on wsgd_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module wsgd_cfg
	import wsgd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale <= SPEED_SCALE_RST;
			cfg_q.gain_slope  <= GAIN_SLOPE_RST;
			cfg_q.gain_offset <= GAIN_OFFSET_RST;
			cfg_q.step_limit  <= STEP_LIMIT_RST;
			cfg_q.deadband    <= DEADBAND_RST;
		end else if (cfg_we) begin
			// Only the register's own width is kept; unknown indexes are dropped.
			unique case (cfg_reg_t'(cfg_index))
				REG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data[15:0];
				REG_GAIN_SLOPE:  cfg_q.gain_slope  <= cfg_data[23:0];
				REG_GAIN_OFFSET: cfg_q.gain_offset <= cfg_data[15:0];
				REG_STEP_LIMIT:  cfg_q.step_limit  <= cfg_data[9:0];
				REG_DEADBAND:    cfg_q.deadband    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/wsgd_smul.sv]
// Bit-serial signed shift-add multiplier shared by the three products.
// Depends on wsgd_pkg for operand widths and the mul_req_t request bundle.
`default_nettype none

module wsgd_smul
	import wsgd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mul_req_t              req,
	output logic                       done,
	output logic signed [MUL_P_W-1:0]  prod
);

	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W:0]   h_q;
	logic [MUL_B_W-1:0]        l_q;
	logic [MUL_CNT_W-1:0]      cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic                      last;
	logic signed [MUL_A_W:0]   a_ext;
	logic signed [MUL_A_W:0]   addend;
	logic signed [MUL_A_W:0]   sum;
	logic [MUL_P_W:0]          full;

	// The sign bit of B carries negative weight, so the last step subtracts A.
	always_comb begin
		last  = (cnt_q == MUL_CNT_W'(MUL_B_W - 1));
		a_ext = {a_q[MUL_A_W-1], a_q};
		if (l_q[0]) begin
			addend = last ? -a_ext : a_ext;
		end else begin
			addend = '0;
		end
		sum  = h_q + addend;
		full = {h_q, l_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			h_q <= '0;
			l_q <= req.b;
		end else if (busy_q) begin
			h_q <= {sum[MUL_A_W], sum[MUL_A_W:1]};
			l_q <= {sum[0], l_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = full[MUL_P_W-1:0];

endmodule

`default_nettype wire

[rtl/wheel_speed_gain_scheduled_drive_top.sv]
// Gain-scheduled wheel speed drive, top level: sequencer, datapath and stream ports.
// Inputs are taken only in idle, once the previous result is in the output register.
// Item rate: three 25-step products on the one shared multiplier, plus output stalls.
// The output register holds a result while the next item is already being worked on.
// Asynchronous active-low reset: registers to defaults, last count 0, drive code 1024.
// Depends on wsgd_pkg, wsgd_cfg and wsgd_smul.
`default_nettype none

module wheel_speed_gain_scheduled_drive_top
	import wsgd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_W-1:0]       s_tdata,   // encoder_count[31:0], target_speed[47:32]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_W-1:0]           m_tdata,   // duty[9:0], forward[10], drive_level[21:11],
	                                              // speed_estimate[45:22], zero pad[47:46]
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LD1  = 9'b000000010,
		ST_W1   = 9'b000000100,
		ST_LD2  = 9'b000001000,
		ST_W2   = 9'b000010000,
		ST_LD3  = 9'b000100000,
		ST_W3   = 9'b001000000,
		ST_DEAD = 9'b010000000,
		ST_ACC  = 9'b100000000
	} state_t;

	cfg_t                      cfg;
	mul_req_t                  mul_req;
	logic                      mul_done;
	logic signed [MUL_P_W-1:0] mul_p;

	state_t       state_q, state_d;
	logic [31:0]  last_count_q;
	logic [10:0]  acc_q;
	logic [31:0]  diff_q;
	logic [15:0]  target_q;
	logic [23:0]  speed_q;
	logic [24:0]  err_q;
	logic [24:0]  gain_q;
	logic [18:0]  step_q;
	logic [10:0]  whole_q;
	logic         m_tvalid_q;
	logic [9:0]   duty_q;
	logic         forward_q;
	logic [10:0]  drive_q;
	logic [23:0]  speed_out_q;

	logic               in_fire;
	logic               out_load;
	logic [31:0]        count_in;
	logic [32:0]        diff_raw;
	logic [31:0]        diff_sat;
	logic [49:0]        speed_sh;
	logic [23:0]        speed_sat;
	logic [23:0]        mag;
	logic [24:0]        err_d;
	logic [24:0]        gain_d;
	logic signed [41:0] step_sh;
	logic signed [41:0] lim_pos;
	logic signed [41:0] lim_neg;
	logic signed [41:0] step_clamped;
	logic [18:0]        step_abs;
	logic [10:0]        whole_d;
	logic [12:0]        acc_sum;
	logic [10:0]        acc_d;
	logic [9:0]         duty_d;
	logic               forward_d;

	wsgd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wsgd_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_ACC) && (!m_tvalid_q || m_tready);

	// Position difference, saturated to 32-bit signed.
	always_comb begin
		count_in = s_tdata[31:0];
		diff_raw = {count_in[31], count_in} - {last_count_q[31], last_count_q};
		if (diff_raw[32] != diff_raw[31]) begin
			diff_sat = diff_raw[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			diff_sat = diff_raw[31:0];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mag             = speed_q[23] ? (24'd0 - speed_q) : speed_q;
		mul_req         = '0;
		if (state_q == ST_LD1) begin
			mul_req.start = 1'b1;
			mul_req.a     = {diff_q[31], diff_q};
			mul_req.b     = {9'd0, cfg.speed_scale};
		end else if (state_q == ST_LD2) begin
			mul_req.start = 1'b1;
			mul_req.a     = {9'd0, mag};
			mul_req.b     = {1'b0, cfg.gain_slope};
		end else if (state_q == ST_LD3) begin
			mul_req.start = 1'b1;
			mul_req.a     = {{8{gain_q[24]}}, gain_q};
			mul_req.b     = err_q;
		end
	end

	// Post-processing of the products.
	always_comb begin
		speed_sh = mul_p[57:8];
		if (speed_sh[49:23] == {27{speed_sh[23]}}) begin
			speed_sat = speed_sh[23:0];
		end else begin
			speed_sat = speed_sh[49] ? 24'h80_0000 : 24'h7F_FFFF;
		end

		err_d  = {speed_q[23], speed_q} - {target_q[15], target_q, 8'd0};
		gain_d = {1'b0, mul_p[47:24]} - {9'd0, cfg.gain_offset};

		step_sh = mul_p[57:16];
		lim_pos = $signed({24'd0, cfg.step_limit, 8'd0});
		lim_neg = -lim_pos;
		if (step_sh > lim_pos) begin
			step_clamped = lim_pos;
		end else if (step_sh < lim_neg) begin
			step_clamped = lim_neg;
		end else begin
			step_clamped = step_sh;
		end

		// Deadband on the clamped step, then floor to whole drive codes.
		step_abs = step_q[18] ? (19'd0 - step_q) : step_q;
		if (step_abs < {3'd0, cfg.deadband}) begin
			whole_d = '0;
		end else begin
			whole_d = step_q[18:8];
		end

		acc_sum = {2'b00, acc_q} + {{2{whole_q[10]}}, whole_q};
		if (acc_sum[12]) begin
			acc_d = '0;
		end else if (acc_sum[11]) begin
			acc_d = DRIVE_MAX;
		end else begin
			acc_d = acc_sum[10:0];
		end

		if (acc_d == DRIVE_STOP_LO || acc_d == DRIVE_STOP_HI) begin
			duty_d    = '0;
			forward_d = 1'b0;
		end else if (acc_d < DRIVE_STOP_LO) begin
			duty_d    = 10'(DRIVE_STOP_LO - acc_d);
			forward_d = 1'b0;
		end else begin
			duty_d    = 10'(acc_d - DRIVE_STOP_HI);
			forward_d = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) begin
				state_d = ST_LD1;
			end
			ST_LD1:  state_d = ST_W1;
			ST_W1:   if (mul_done) begin
				state_d = ST_LD2;
			end
			ST_LD2:  state_d = ST_W2;
			ST_W2:   if (mul_done) begin
				state_d = ST_LD3;
			end
			ST_LD3:  state_d = ST_W3;
			ST_W3:   if (mul_done) begin
				state_d = ST_DEAD;
			end
			ST_DEAD: state_d = ST_ACC;
			ST_ACC:  if (out_load) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_count_q <= '0;
			acc_q        <= DRIVE_RESET;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				last_count_q <= count_in;
			end
			if (out_load) begin
				acc_q      <= acc_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			diff_q   <= diff_sat;
			target_q <= s_tdata[47:32];
		end
		if (state_q == ST_W1 && mul_done) begin
			speed_q <= speed_sat;
		end
		if (state_q == ST_LD2) begin
			err_q <= err_d;
		end
		if (state_q == ST_W2 && mul_done) begin
			gain_q <= gain_d;
		end
		if (state_q == ST_W3 && mul_done) begin
			step_q <= step_clamped[18:0];
		end
		if (state_q == ST_DEAD) begin
			whole_q <= whole_d;
		end
		if (out_load) begin
			duty_q      <= duty_d;
			forward_q   <= forward_d;
			drive_q     <= acc_d;
			speed_out_q <= speed_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, speed_out_q, drive_q, forward_q, duty_q};

endmodule

`default_nettype wire
